[rtl/hcle_pkg.sv]
// ----------------------------------------------------------------------------
// hcle_pkg
// Shared constants, types and name tables of the content-length extractor.
// ----------------------------------------------------------------------------
package hcle_pkg;

	localparam int MAX_SEARCH = 10;
	localparam int MAX_DIGITS = 10;
	localparam int NAME_LEN   = 14;
	localparam int NAME_IW    = $clog2(NAME_LEN);
	localparam int SEARCH_W   = $clog2(MAX_SEARCH + 1);
	localparam int DIGIT_W    = $clog2(MAX_DIGITS + 1);
	localparam int BYTE_W     = 8;
	localparam int LEN_W      = 34;

	// class queue and result queue depths, powers of two
	localparam int CQ_DEPTH = 4;
	localparam int CQ_AW    = $clog2(CQ_DEPTH);
	localparam int RQ_DEPTH = 2;
	localparam int RQ_AW    = $clog2(RQ_DEPTH);

	localparam logic [BYTE_W-1:0] CH_CR   = 8'h0d;
	localparam logic [BYTE_W-1:0] CH_LF   = 8'h0a;
	localparam logic [BYTE_W-1:0] CH_NUL  = 8'h00;
	localparam logic [BYTE_W-1:0] CH_0    = 8'h30;
	localparam logic [BYTE_W-1:0] CH_1    = 8'h31;
	localparam logic [BYTE_W-1:0] CH_9    = 8'h39;

	typedef enum logic [1:0] {
		HIST_NONE   = 2'd0,
		HIST_CR     = 2'd1,
		HIST_CRLF   = 2'd2,
		HIST_CRLFCR = 2'd3
	} hist_t;

	typedef enum logic [5:0] {
		MODE_FIRST  = 6'b000001,
		MODE_MATCH  = 6'b000010,
		MODE_SKIP   = 6'b000100,
		MODE_SEARCH = 6'b001000,
		MODE_DIGITS = 6'b010000,
		MODE_DONE   = 6'b100000
	} mode_t;

	typedef struct packed {
		logic [NAME_LEN-1:0] name_hit;
		logic [3:0]          digit;
		logic                is_digit;
		logic                is_nz_digit;
		logic                is_cr;
		logic                is_lf;
		logic                is_term;
	} byte_class_t;

	function automatic logic [BYTE_W-1:0] name_lower(input logic [NAME_IW-1:0] idx);
		logic [BYTE_W-1:0] c;
		case (idx)
			4'd0:    c = "c";
			4'd1:    c = "o";
			4'd2:    c = "n";
			4'd3:    c = "t";
			4'd4:    c = "e";
			4'd5:    c = "n";
			4'd6:    c = "t";
			4'd7:    c = "-";
			4'd8:    c = "l";
			4'd9:    c = "e";
			4'd10:   c = "n";
			4'd11:   c = "g";
			4'd12:   c = "t";
			4'd13:   c = "h";
			default: c = CH_NUL;
		endcase
		return c;
	endfunction

	function automatic logic [BYTE_W-1:0] name_upper(input logic [NAME_IW-1:0] idx);
		logic [BYTE_W-1:0] c;
		c = name_lower(idx);
		if (c inside {["a":"z"]}) begin
			c = c & 8'hdf;
		end
		return c;
	endfunction

endpackage

[rtl/http_content_length_extractor_unit.sv]
// ----------------------------------------------------------------------------
// http_content_length_extractor_unit
// Extracts the content-length value from a byte-serial HTTP response header.
// ----------------------------------------------------------------------------
// One header byte is taken per clock, sustained. The front classifies each
// byte into a four-entry class queue; the back parses one record per clock
// and, on the last byte of a message, writes the length (0 if none) into a
// two-entry result queue, visible after the class and result queue writes.
// The back holds a message-ending record only while the result queue is
// full, so input rate drops below one byte per clock only when results are
// not popped.
module http_content_length_extractor_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [hcle_pkg::BYTE_W-1:0] data_byte,
	input  logic                       end_of_message,
	output logic                       empty,
	input  logic                       pop,
	output logic [hcle_pkg::LEN_W-1:0] content_length
);
	import hcle_pkg::*;

	logic        cq_valid;
	logic        cq_take;
	byte_class_t cq_item;

	hcle_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.data_byte      (data_byte),
		.end_of_message (end_of_message),
		.cq_valid       (cq_valid),
		.cq_item        (cq_item),
		.cq_take        (cq_take)
	);

	hcle_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cq_valid       (cq_valid),
		.cq_item        (cq_item),
		.cq_take        (cq_take),
		.empty          (empty),
		.pop            (pop),
		.content_length (content_length)
	);

endmodule

[rtl/hcle_front.sv]
// ----------------------------------------------------------------------------
// hcle_front
// Accepts header bytes, classifies each one and queues the class record.
// ----------------------------------------------------------------------------
module hcle_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       full,
	input  logic [hcle_pkg::BYTE_W-1:0] data_byte,
	input  logic                       end_of_message,
	output logic                       cq_valid,
	output hcle_pkg::byte_class_t      cq_item,
	input  logic                       cq_take
);
	import hcle_pkg::*;

	byte_class_t      cls;
	byte_class_t      cq_mem_q [CQ_DEPTH];
	logic [CQ_AW-1:0] wr_ptr_q;
	logic [CQ_AW-1:0] rd_ptr_q;
	logic [CQ_AW:0]   cnt_q;
	logic             wr_en;
	logic             rd_en;

	always_comb begin
		for (int i = 0; i < NAME_LEN; i++) begin
			cls.name_hit[i] = (data_byte == name_lower(NAME_IW'(i))) ||
				(data_byte == name_upper(NAME_IW'(i)));
		end
		cls.digit       = data_byte[3:0];
		cls.is_digit    = (data_byte >= CH_0) && (data_byte <= CH_9);
		cls.is_nz_digit = (data_byte >= CH_1) && (data_byte <= CH_9);
		cls.is_cr       = data_byte == CH_CR;
		cls.is_lf       = data_byte == CH_LF;
		cls.is_term     = end_of_message || (data_byte == CH_NUL);
	end

	assign full     = cnt_q == (CQ_AW + 1)'(CQ_DEPTH);
	assign cq_valid = cnt_q != '0;
	assign cq_item  = cq_mem_q[rd_ptr_q];
	assign wr_en    = push && !full;
	assign rd_en    = cq_take && cq_valid;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			cq_mem_q[wr_ptr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!wr_en && rd_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_cq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && !rd_en) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("class queue count did not follow a lone write");
	a_cq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (CQ_AW + 1)'(CQ_DEPTH))
		else $error("class queue count beyond depth");
`endif

endmodule

[rtl/hcle_back.sv]
// ----------------------------------------------------------------------------
// hcle_back
// Runs the header parse on queued class records and queues one length per
// message.
// ----------------------------------------------------------------------------
module hcle_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cq_valid,
	input  hcle_pkg::byte_class_t      cq_item,
	output logic                       cq_take,
	output logic                       empty,
	input  logic                       pop,
	output logic [hcle_pkg::LEN_W-1:0] content_length
);
	import hcle_pkg::*;

	mode_t               mode_q, mode_d;
	hist_t               hist_q, hist_d;
	logic [NAME_IW-1:0]  nidx_q, nidx_d;
	logic [SEARCH_W-1:0] scnt_q, scnt_d;
	logic [DIGIT_W-1:0]  dcnt_q, dcnt_d;
	logic [LEN_W-1:0]    acc_q, acc_d;
	logic [LEN_W-1:0]    acc_x10;
	logic                line_start;
	logic                end_now;
	logic                step;

	logic [LEN_W-1:0]    rq_mem_q [RQ_DEPTH];
	logic [RQ_AW-1:0]    rq_wr_q;
	logic [RQ_AW-1:0]    rq_rd_q;
	logic [RQ_AW:0]      rq_cnt_q;
	logic                rq_push;
	logic                rq_pop;

	assign line_start = cq_item.is_lf && (hist_q == HIST_CR);
	assign end_now    = cq_item.is_term || (cq_item.is_lf && (hist_q == HIST_CRLFCR));
	assign step       = cq_valid && (!end_now || (rq_cnt_q != (RQ_AW + 1)'(RQ_DEPTH)));
	assign cq_take    = step;
	assign acc_x10    = {acc_q[LEN_W-4:0], 3'b000} + {acc_q[LEN_W-2:0], 1'b0} +
		LEN_W'(cq_item.digit);

	always_comb begin
		mode_d = mode_q;
		nidx_d = nidx_q;
		scnt_d = scnt_q;
		dcnt_d = dcnt_q;
		acc_d  = acc_q;

		if (cq_item.is_cr) begin
			hist_d = (hist_q == HIST_CRLF) ? HIST_CRLFCR : HIST_CR;
		end else if (line_start) begin
			hist_d = HIST_CRLF;
		end else begin
			hist_d = HIST_NONE;
		end

		case (mode_q)
			MODE_FIRST, MODE_SKIP: begin
				if (line_start) begin
					mode_d = MODE_MATCH;
					nidx_d = '0;
				end
			end
			MODE_MATCH: begin
				if (cq_item.name_hit[nidx_q]) begin
					nidx_d = nidx_q + 1'b1;
					if (nidx_q == NAME_IW'(NAME_LEN - 1)) begin
						mode_d = MODE_SEARCH;
						scnt_d = '0;
					end
				end else begin
					mode_d = MODE_SKIP;
				end
			end
			MODE_SEARCH: begin
				if (cq_item.is_nz_digit) begin
					acc_d  = LEN_W'(cq_item.digit);
					dcnt_d = DIGIT_W'(1);
					mode_d = (MAX_DIGITS <= 1) ? MODE_DONE : MODE_DIGITS;
				end else if (scnt_q >= SEARCH_W'(MAX_SEARCH)) begin
					acc_d  = '0;
					mode_d = MODE_DONE;
				end else begin
					scnt_d = scnt_q + 1'b1;
				end
			end
			MODE_DIGITS: begin
				if (cq_item.is_digit) begin
					acc_d  = acc_x10;
					dcnt_d = dcnt_q + 1'b1;
					if ((dcnt_q + 1'b1) >= DIGIT_W'(MAX_DIGITS)) begin
						mode_d = MODE_DONE;
					end
				end else begin
					mode_d = MODE_DONE;
				end
			end
			default: begin
			end
		endcase
	end

	assign rq_push        = step && end_now;
	assign rq_pop         = pop && !empty;
	assign empty          = rq_cnt_q == '0;
	assign content_length = rq_mem_q[rq_rd_q];

	always_ff @(posedge clk) begin
		if (rq_push) begin
			rq_mem_q[rq_wr_q] <= acc_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_FIRST;
			hist_q <= HIST_NONE;
			nidx_q <= '0;
			scnt_q <= '0;
			dcnt_q <= '0;
			acc_q  <= '0;
		end else if (step) begin
			if (end_now) begin
				mode_q <= MODE_FIRST;
				hist_q <= HIST_NONE;
				nidx_q <= '0;
				scnt_q <= '0;
				dcnt_q <= '0;
				acc_q  <= '0;
			end else begin
				mode_q <= mode_d;
				hist_q <= hist_d;
				nidx_q <= nidx_d;
				scnt_q <= scnt_d;
				dcnt_q <= dcnt_d;
				acc_q  <= acc_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_wr_q  <= '0;
			rq_rd_q  <= '0;
			rq_cnt_q <= '0;
		end else begin
			if (rq_push) begin
				rq_wr_q <= rq_wr_q + 1'b1;
			end
			if (rq_pop) begin
				rq_rd_q <= rq_rd_q + 1'b1;
			end
			if (rq_push && !rq_pop) begin
				rq_cnt_q <= rq_cnt_q + 1'b1;
			end else if (!rq_push && rq_pop) begin
				rq_cnt_q <= rq_cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(step && end_now) |=> ((mode_q == MODE_FIRST) && (acc_q == '0)))
		else $error("parse state not cleared after message end");
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == MODE_DIGITS) |-> ((dcnt_q != '0) && (dcnt_q < DIGIT_W'(MAX_DIGITS))))
		else $error("digit count out of range while taking digits");
	a_acc_idle: assert property (@(posedge clk) disable iff (!arst_n)
		((mode_q == MODE_FIRST) || (mode_q == MODE_MATCH) || (mode_q == MODE_SKIP) ||
			(mode_q == MODE_SEARCH)) |-> (acc_q == '0))
		else $error("accumulator nonzero before first digit");
	a_rq_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rq_cnt_q <= (RQ_AW + 1)'(RQ_DEPTH))
		else $error("result queue count beyond depth");
`endif

endmodule
